[rtl/track_conversion_tagger_assert.svh]
// Assertion macros used by the top-level RTL of the conversion tagger.
`ifndef TRACK_CONVERSION_TAGGER_ASSERT_SVH
`define TRACK_CONVERSION_TAGGER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define TCT_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TCT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/tct_pkg.sv]
`timescale 1ns / 1ps

package tct_pkg;

  localparam int CNT_W      = 8;
  localparam int PT_W       = 24;
  localparam int D0_W       = 19;
  localparam int MAG_W      = 19;
  localparam int SUM_W      = CNT_W + 1;
  localparam int FRAC_W     = 16;
  localparam int RATIO_W    = 25;
  localparam int ROOT_W     = 25;
  localparam int COEF_W     = 24;
  localparam int PROD_W     = 42;
  localparam int RAD_W      = PROD_W + FRAC_W;
  localparam int SUB_W      = 60;
  localparam int SLOPE_W    = COEF_W + ROOT_W;
  localparam int CMP_W      = SLOPE_W + 1;
  localparam int OFS_SHIFT  = 8;
  localparam int RAD_DIV    = 300;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Pipeline depth: the front end, then a step for each root bit, then the cut.
  localparam int PIPE_DEPTH = 2 + ROOT_W + 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VERSION     = 3'd0,
    CFG_RATIO_EN    = 3'd1,
    CFG_SLOPE_NO    = 3'd2,
    CFG_OFFSET_NO   = 3'd3,
    CFG_SLOPE_WITH  = 3'd4,
    CFG_OFFSET_WITH = 3'd5
  } cfg_idx_t;

  localparam logic              RST_VERSION     = 1'b1;
  localparam logic              RST_RATIO_EN    = 1'b1;
  localparam logic [COEF_W-1:0] RST_SLOPE_NO    = 24'd5033;
  localparam logic [COEF_W-1:0] RST_OFFSET_NO   = 24'd2894070;
  localparam logic [COEF_W-1:0] RST_SLOPE_WITH  = 24'd5033;
  localparam logic [COEF_W-1:0] RST_OFFSET_WITH = 24'd3397386;

  typedef struct packed {
    logic [COEF_W-1:0] slope_no;
    logic [COEF_W-1:0] offset_no;
    logic [COEF_W-1:0] slope_with;
    logic [COEF_W-1:0] offset_with;
  } cut_cfg_t;

  typedef struct packed {
    logic               test;
    logic               ratio_zero;
    logic [SUM_W-1:0]   num;
    logic [SUM_W-1:0]   den;
    logic [SUM_W-1:0]   div_rem;
    logic [RATIO_W-1:0] quo;
    logic [RAD_W-1:0]   sq_rem;
    logic [ROOT_W-1:0]  root;
  } work_t;

endpackage

[rtl/tct_front.sv]
`timescale 1ns / 1ps

module tct_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_vld,
  input  logic [tct_pkg::CNT_W-1:0] inner_layer_hits,
  input  logic                      inner_hit_expected,
  input  logic [tct_pkg::CNT_W-1:0] high_thr_hits,
  input  logic [tct_pkg::CNT_W-1:0] high_thr_outliers,
  input  logic [tct_pkg::CNT_W-1:0] xenon_hits,
  input  logic [tct_pkg::CNT_W-1:0] straw_hits,
  input  logic [tct_pkg::CNT_W-1:0] straw_outliers,
  input  logic [tct_pkg::PT_W-1:0]  pt_mev,
  input  logic signed [tct_pkg::D0_W-1:0] d0_um,
  input  logic                      version_select,
  input  logic                      ratio_enable,
  output logic                      out_vld,
  output tct_pkg::work_t            out_item
);
  import tct_pkg::*;

  logic             s1_vld;
  logic             s1_test;
  logic             s1_zero;
  logic [SUM_W-1:0] s1_num;
  logic [SUM_W-1:0] s1_den;
  logic [MAG_W-1:0] s1_mag;
  logic [PT_W-1:0]  s1_pt;

  logic [SUM_W-1:0]  num;
  logic [SUM_W-1:0]  den;
  logic [MAG_W-1:0]  mag;
  logic              test;
  logic [PROD_W-1:0] prod;

  always_comb begin
    num  = {1'b0, high_thr_hits} + {1'b0, high_thr_outliers};
    den  = (xenon_hits != '0) ? {1'b0, xenon_hits}
                              : {1'b0, straw_hits} + {1'b0, straw_outliers};
    // The most negative d0 maps to 2^18, which still fits the unsigned magnitude.
    mag  = d0_um[D0_W-1] ? (~d0_um + 1'b1) : d0_um;
    test = (inner_layer_hits == '0) && (version_select || inner_hit_expected);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    s1_test <= test;
    s1_zero <= !ratio_enable || (den == '0);
    s1_num  <= num;
    s1_den  <= den;
    s1_mag  <= mag;
    s1_pt   <= pt_mev;
  end

  assign prod = PROD_W'(s1_mag) * PROD_W'(s1_pt);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_item.test       <= s1_test;
    out_item.ratio_zero <= s1_zero;
    out_item.num        <= s1_num;
    out_item.den        <= s1_den;
    out_item.div_rem    <= '0;
    out_item.quo        <= '0;
    out_item.sq_rem     <= {prod, {FRAC_W{1'b0}}};
    out_item.root       <= '0;
  end

endmodule

[rtl/tct_step.sv]
`timescale 1ns / 1ps

// One quotient bit of the ratio divider and one bit of the radius root per cycle.
module tct_step #(
  parameter int BIT = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_vld,
  input  tct_pkg::work_t in_item,
  output logic           out_vld,
  output tct_pkg::work_t out_item
);
  import tct_pkg::*;

  logic [RATIO_W-1:0] dividend;
  logic [SUM_W:0]     shifted;
  logic [SUB_W-1:0]   root300;
  logic [SUB_W-1:0]   sub;
  logic [SUB_W-1:0]   rem_ext;
  work_t              item_next;

  always_comb begin
    item_next = in_item;
    dividend  = {in_item.num, {FRAC_W{1'b0}}};
    shifted   = {in_item.div_rem, dividend[BIT]};
    if (shifted >= {1'b0, in_item.den}) begin
      item_next.div_rem  = SUM_W'(shifted - {1'b0, in_item.den});
      item_next.quo[BIT] = 1'b1;
    end else begin
      item_next.div_rem = SUM_W'(shifted);
    end

    // Remainder holds y - 300*r^2; setting bit k takes 300*(r*2^(k+1) + 2^(2k)) off it.
    root300 = (SUB_W'(in_item.root) << 8) + (SUB_W'(in_item.root) << 5)
            + (SUB_W'(in_item.root) << 3) + (SUB_W'(in_item.root) << 2);
    sub     = (root300 << (BIT + 1)) + (SUB_W'(RAD_DIV) << (2 * BIT));
    rem_ext = SUB_W'(in_item.sq_rem);
    if (rem_ext >= sub) begin
      item_next.sq_rem    = RAD_W'(rem_ext - sub);
      item_next.root[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_item <= item_next;
  end

endmodule

[rtl/tct_cut.sv]
`timescale 1ns / 1ps

module tct_cut (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_vld,
  input  tct_pkg::work_t              in_item,
  input  tct_pkg::cut_cfg_t           cut_cfg,
  output logic                        done,
  output logic                        is_conversion,
  output logic [tct_pkg::RATIO_W-1:0] ht_ratio,
  output logic [tct_pkg::ROOT_W-1:0]  conv_radius
);
  import tct_pkg::*;

  logic [COEF_W-1:0]  slope;
  logic [COEF_W-1:0]  offset;
  logic               sa_vld;
  logic [RATIO_W-1:0] sa_ratio;
  logic [ROOT_W-1:0]  sa_root;
  logic [COEF_W-1:0]  sa_offset;
  logic [SLOPE_W-1:0] sa_slope_term;
  logic [CMP_W-1:0]   lhs;
  logic [CMP_W-1:0]   rhs;

  assign slope  = in_item.test ? cut_cfg.slope_no  : cut_cfg.slope_with;
  assign offset = in_item.test ? cut_cfg.offset_no : cut_cfg.offset_with;

  always_ff @(posedge clk) begin
    if (rst) begin
      sa_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      sa_vld <= in_vld;
      done   <= sa_vld;
    end
  end

  always_ff @(posedge clk) begin
    sa_ratio      <= in_item.ratio_zero ? '0 : in_item.quo;
    sa_root       <= in_item.root;
    sa_offset     <= offset;
    sa_slope_term <= SLOPE_W'(slope) * SLOPE_W'(in_item.root);
  end

  // ratio > b - a*r is compared as ratio*2^16 + a*r > b*2^8, which never goes negative.
  assign lhs = (CMP_W'(sa_ratio) << FRAC_W) + CMP_W'(sa_slope_term);
  assign rhs = CMP_W'(sa_offset) << OFS_SHIFT;

  always_ff @(posedge clk) begin
    is_conversion <= lhs > rhs;
    ht_ratio      <= sa_ratio;
    conv_radius   <= sa_root;
  end

endmodule

[rtl/track_conversion_tagger.sv]
`timescale 1ns / 1ps

// Conversion tagger for one track per clock. A request is taken whenever start is high
// and busy is low; busy is high only during reset. Every request gives exactly one
// result, shown on the result ports with done high for a single cycle, after the
// request has passed the front end (count sums, |d0| and the d0*pt product), a
// pipelined one-bit-per-stage divider and square root that yield one bit of ratio
// and radius each, and the cut (a*radius product, then the compare).
// Results cannot be held off, so the receiver must take each one in the cycle it shows.
// Configuration writes are taken whenever reset is low but should only be issued while
// no request is in flight.
module track_conversion_tagger (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tct_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tct_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [tct_pkg::CNT_W-1:0]      inner_layer_hits,
  input  logic                           inner_hit_expected,
  input  logic [tct_pkg::CNT_W-1:0]      high_thr_hits,
  input  logic [tct_pkg::CNT_W-1:0]      high_thr_outliers,
  input  logic [tct_pkg::CNT_W-1:0]      xenon_hits,
  input  logic [tct_pkg::CNT_W-1:0]      straw_hits,
  input  logic [tct_pkg::CNT_W-1:0]      straw_outliers,
  input  logic [tct_pkg::PT_W-1:0]       pt_mev,
  input  logic signed [tct_pkg::D0_W-1:0] d0_um,
  output logic                           done,
  output logic                           is_conversion,
  output logic [tct_pkg::RATIO_W-1:0]    ht_ratio,
  output logic [tct_pkg::ROOT_W-1:0]     conv_radius
);
  import tct_pkg::*;
  `include "track_conversion_tagger_assert.svh"

  logic     version_select;
  logic     ratio_enable;
  cut_cfg_t cut_cfg;
  logic     cfg_write;

  logic  chain_vld  [0:ROOT_W];
  work_t chain_item [0:ROOT_W];

  assign busy      = rst;
  assign cfg_ready = !rst;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      version_select      <= RST_VERSION;
      ratio_enable        <= RST_RATIO_EN;
      cut_cfg.slope_no    <= RST_SLOPE_NO;
      cut_cfg.offset_no   <= RST_OFFSET_NO;
      cut_cfg.slope_with  <= RST_SLOPE_WITH;
      cut_cfg.offset_with <= RST_OFFSET_WITH;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_VERSION:     version_select      <= cfg_data[0];
        CFG_RATIO_EN:    ratio_enable        <= cfg_data[0];
        CFG_SLOPE_NO:    cut_cfg.slope_no    <= cfg_data;
        CFG_OFFSET_NO:   cut_cfg.offset_no   <= cfg_data;
        CFG_SLOPE_WITH:  cut_cfg.slope_with  <= cfg_data;
        CFG_OFFSET_WITH: cut_cfg.offset_with <= cfg_data;
        default: ;
      endcase
    end
  end

  tct_front u_front (
    .clk                (clk),
    .rst                (rst),
    .in_vld             (start && !busy),
    .inner_layer_hits   (inner_layer_hits),
    .inner_hit_expected (inner_hit_expected),
    .high_thr_hits      (high_thr_hits),
    .high_thr_outliers  (high_thr_outliers),
    .xenon_hits         (xenon_hits),
    .straw_hits         (straw_hits),
    .straw_outliers     (straw_outliers),
    .pt_mev             (pt_mev),
    .d0_um              (d0_um),
    .version_select     (version_select),
    .ratio_enable       (ratio_enable),
    .out_vld            (chain_vld[0]),
    .out_item           (chain_item[0])
  );

  for (genvar g = 0; g < ROOT_W; g++) begin : g_step
    tct_step #(
      .BIT (ROOT_W - 1 - g)
    ) u_step (
      .clk      (clk),
      .rst      (rst),
      .in_vld   (chain_vld[g]),
      .in_item  (chain_item[g]),
      .out_vld  (chain_vld[g+1]),
      .out_item (chain_item[g+1])
    );
  end

  tct_cut u_cut (
    .clk           (clk),
    .rst           (rst),
    .in_vld        (chain_vld[ROOT_W]),
    .in_item       (chain_item[ROOT_W]),
    .cut_cfg       (cut_cfg),
    .done          (done),
    .is_conversion (is_conversion),
    .ht_ratio      (ht_ratio),
    .conv_radius   (conv_radius)
  );

  `TCT_ASSERT_IMPLY(a_done_latency, clk, rst, done, $past(start && !busy, PIPE_DEPTH), "result without a request at the pipeline depth")
  `TCT_ASSERT_IMPLY(a_ratio_off, clk, rst, done && !ratio_enable, ht_ratio == '0, "ratio not zero while disabled")
  `TCT_ASSERT_IMPLY(a_zero_no_conv, clk, rst, done && (ht_ratio == '0) && (conv_radius == '0), !is_conversion, "flag set with zero ratio and radius")
  `TCT_ASSERT_NEXT(a_cfg_ratio_en, clk, rst, cfg_write && (cfg_index == CFG_RATIO_EN), ratio_enable == $past(cfg_data[0]), "ratio enable write lost")

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import tct_pkg::*;

  typedef struct {
    logic [CNT_W-1:0]       inner;
    logic                   inner_exp;
    logic [CNT_W-1:0]       ht_hits;
    logic [CNT_W-1:0]       ht_outl;
    logic [CNT_W-1:0]       xenon;
    logic [CNT_W-1:0]       hits;
    logic [CNT_W-1:0]       outl;
    logic [PT_W-1:0]        pt;
    logic signed [D0_W-1:0] d0;
  } track_t;

  typedef struct {
    logic               conv;
    logic [RATIO_W-1:0] ratio;
    logic [ROOT_W-1:0]  radius;
  } tag_t;

  class tag_scoreboard;
    logic              version;
    logic              ratio_en;
    logic [COEF_W-1:0] slope_no, offset_no, slope_with, offset_with;
    tag_t              pending[$];
    int                errors;
    int                tracks;
    int                flagged;

    function void reset_regs();
      version     = RST_VERSION;
      ratio_en    = RST_RATIO_EN;
      slope_no    = RST_SLOPE_NO;
      offset_no   = RST_OFFSET_NO;
      slope_with  = RST_SLOPE_WITH;
      offset_with = RST_OFFSET_WITH;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_VERSION:     version = data[0];
        CFG_RATIO_EN:    ratio_en = data[0];
        CFG_SLOPE_NO:    slope_no = data;
        CFG_OFFSET_NO:   offset_no = data;
        CFG_SLOPE_WITH:  slope_with = data;
        CFG_OFFSET_WITH: offset_with = data;
        default: ;
      endcase
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int i = 29; i >= 0; i--) begin
        trial = root | (64'd1 << i);
        if (trial * trial <= v) root = trial;
      end
      return root;
    endfunction

    function void note_track(track_t t);
      longint unsigned num, den, ratio, mag, radius, a, b;
      longint          d;
      logic            test;
      tag_t            e;
      num = t.ht_hits + t.ht_outl;
      den = (t.xenon != 0) ? t.xenon : t.hits + t.outl;
      ratio = (ratio_en && den != 0) ? (num << 16) / den : 0;
      d = t.d0;
      mag = (d < 0) ? -d : d;
      radius = int_sqrt(((mag * t.pt) << 16) / RAD_DIV);
      test = (t.inner == 0) && (version || t.inner_exp);
      a = test ? slope_no : slope_with;
      b = test ? offset_no : offset_with;
      e.conv = ((ratio << 16) + a * radius) > (b << OFS_SHIFT);
      e.ratio = RATIO_W'(ratio);
      e.radius = ROOT_W'(radius);
      pending.push_back(e);
      tracks++;
    endfunction

    function void check_tag(tag_t got);
      tag_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result conv=%0d ratio=%0d radius=%0d",
                 $time, got.conv, got.ratio, got.radius);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.conv) flagged++;
      if (got.conv !== e.conv) begin
        $display("%0t: is_conversion expected %0d actual %0d", $time, e.conv, got.conv);
        errors++;
      end
      if (got.ratio !== e.ratio) begin
        $display("%0t: ht_ratio expected %0d actual %0d", $time, e.ratio, got.ratio);
        errors++;
      end
      if (got.radius !== e.radius) begin
        $display("%0t: conv_radius expected %0d actual %0d", $time, e.radius, got.radius);
        errors++;
      end
    endfunction
  endclass

  logic                   clk, rst, start, busy, done;
  logic                   cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic [CNT_W-1:0]       inner_layer_hits, high_thr_hits, high_thr_outliers;
  logic [CNT_W-1:0]       xenon_hits, straw_hits, straw_outliers;
  logic                   inner_hit_expected;
  logic [PT_W-1:0]        pt_mev;
  logic signed [D0_W-1:0] d0_um;
  logic                   is_conversion;
  logic [RATIO_W-1:0]     ht_ratio;
  logic [ROOT_W-1:0]      conv_radius;

  tag_scoreboard sb;
  bit            idling;
  int            quiet_cycles;
  int            cfg_writes;

  track_conversion_tagger dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Sampling at the edge sees values from before the edge.
  always @(posedge clk) begin
    if (!rst && ((start && !busy) || done || (cfg_valid && cfg_ready))) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (!rst) begin
      if (start && !busy) begin
        sb.note_track('{inner_layer_hits, inner_hit_expected, high_thr_hits,
                        high_thr_outliers, xenon_hits, straw_hits, straw_outliers,
                        pt_mev, d0_um});
      end
      if (done) begin
        sb.check_tag('{is_conversion, ht_ratio, conv_radius});
      end
      if (cfg_valid && cfg_ready) begin
        sb.write_reg(cfg_index, cfg_data);
        cfg_writes++;
      end
    end
    if (quiet_cycles > 3000) begin
      $display("%0t: timeout, nothing moving", $time);
      $display("FAIL track_conversion_tagger");
      $finish;
    end
  end

  task automatic send_track(track_t t);
    inner_layer_hits   <= t.inner;
    inner_hit_expected <= t.inner_exp;
    high_thr_hits      <= t.ht_hits;
    high_thr_outliers  <= t.ht_outl;
    xenon_hits         <= t.xenon;
    straw_hits         <= t.hits;
    straw_outliers     <= t.outl;
    pt_mev             <= t.pt;
    d0_um              <= t.d0;
    start              <= 1'b1;
    do @(posedge clk); while (busy);
    if (idling && $urandom_range(0, 7) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
  endtask

  // Each write is followed by a stretch with valid low, of random length while idling.
  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    repeat ((idling && $urandom_range(0, 1) != 0) ? $urandom_range(1, 19) : 1)
      @(posedge clk);
  endtask

  function automatic track_t rand_track();
    track_t t;
    t.inner     = ($urandom_range(0, 2) == 0) ? CNT_W'($urandom_range(1, 255)) : '0;
    t.inner_exp = 1'($urandom_range(0, 1));
    t.ht_hits   = CNT_W'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 12));
    t.ht_outl   = CNT_W'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 6));
    t.xenon     = CNT_W'(($urandom_range(0, 3) == 0) ? 0 :
                  (($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 40)));
    t.hits      = CNT_W'(($urandom_range(0, 5) == 0) ? 0 : $urandom);
    t.outl      = CNT_W'(($urandom_range(0, 5) == 0) ? 0 : $urandom);
    case ($urandom_range(0, 3))
      0: t.pt = PT_W'($urandom);
      1: t.pt = PT_W'($urandom_range(500, 5000));
      default: t.pt = PT_W'($urandom_range(1000, 100000));
    endcase
    case ($urandom_range(0, 5))
      0: t.d0 = D0_W'($urandom);
      1: t.d0 = $urandom_range(0, 1) ? -19'sd262144 : 19'sd262143;
      default: t.d0 = $signed(19'($urandom_range(0, 4000))) - 19'sd2000;
    endcase
    return t;
  endfunction

  function automatic track_t mk(int inner, int ex, int hh, int ho, int xe, int sh,
                                int so, int pt, int d0);
    track_t t;
    t.inner     = CNT_W'(inner);
    t.inner_exp = 1'(ex);
    t.ht_hits   = CNT_W'(hh);
    t.ht_outl   = CNT_W'(ho);
    t.xenon     = CNT_W'(xe);
    t.hits      = CNT_W'(sh);
    t.outl      = CNT_W'(so);
    t.pt        = PT_W'(pt);
    t.d0        = D0_W'(d0);
    return t;
  endfunction

  initial begin
    track_t directed[$];
    sb = new();
    sb.reset_regs();
    idling = 1;
    quiet_cycles = 0;
    cfg_writes = 0;
    rst = 1;
    start = 0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    inner_layer_hits = '0;
    inner_hit_expected = 0;
    high_thr_hits = '0;
    high_thr_outliers = '0;
    xenon_hits = '0;
    straw_hits = '0;
    straw_outliers = '0;
    pt_mev = '0;
    d0_um = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Edge cases: zero divisors, fallback divisor, field extremes, d0 extremes.
    directed = '{
      mk(0, 0, 0, 0, 0, 0, 0, 0, 0),
      mk(0, 1, 5, 2, 0, 0, 0, 2000, 100),
      mk(255, 1, 255, 255, 1, 0, 0, 16777215, 262143),
      mk(0, 1, 255, 255, 0, 255, 255, 16777215, -262144),
      mk(1, 0, 3, 1, 0, 20, 4, 1000, -50),
      mk(0, 0, 10, 0, 40, 0, 0, 3000, 300),
      mk(128, 1, 0, 0, 255, 255, 255, 1, -1),
      mk(0, 1, 1, 0, 255, 0, 0, 16777215, 262143),
      mk(255, 0, 8, 4, 30, 30, 2, 5000, 20),
      mk(0, 1, 9, 3, 35, 40, 3, 10000, 1000),
      mk(0, 0, 0, 0, 0, 0, 1, 300, 1),
      mk(2, 1, 200, 0, 0, 1, 0, 8388608, -131072),
      mk(0, 1, 7, 7, 0, 0, 0, 4095, 4095)
    };
    foreach (directed[i]) send_track(directed[i]);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: ;
        1: begin
          write_reg(CFG_VERSION, 24'h000000);
          write_reg(CFG_RATIO_EN, 24'hFFFFFE);
        end
        2: begin
          write_reg(CFG_SLOPE_NO, 24'hFFFFFF);
          write_reg(CFG_OFFSET_NO, 24'hFFFFFF);
          write_reg(CFG_SLOPE_WITH, 24'hFFFFFF);
          write_reg(CFG_OFFSET_WITH, 24'hFFFFFF);
          write_reg(CFG_RATIO_EN, 24'h000001);
        end
        3: begin
          write_reg(CFG_SLOPE_NO, 24'h000000);
          write_reg(CFG_OFFSET_NO, 24'h000000);
          write_reg(CFG_SLOPE_WITH, 24'h000000);
          write_reg(CFG_OFFSET_WITH, 24'h000000);
          write_reg(CFG_VERSION, 24'hFFFFFF);
        end
        4: begin
          // Indexes past the register list must leave everything alone.
          write_reg(cfg_idx_t'(3'd6), CFG_DATA_W'($urandom));
          write_reg(cfg_idx_t'(3'd7), CFG_DATA_W'($urandom));
          write_reg(CFG_RATIO_EN, 24'h000000);
        end
        default: begin
          write_reg(CFG_VERSION, CFG_DATA_W'($urandom));
          write_reg(CFG_RATIO_EN, $urandom_range(0, 3) == 0 ? 24'h0 : 24'h1);
          write_reg(CFG_SLOPE_NO, CFG_DATA_W'($urandom_range(0, 20000)));
          write_reg(CFG_OFFSET_NO, CFG_DATA_W'($urandom_range(0, 8000000)));
          write_reg(CFG_SLOPE_WITH, CFG_DATA_W'($urandom));
          write_reg(CFG_OFFSET_WITH, CFG_DATA_W'($urandom));
        end
      endcase
      for (int n = 0; n < 142; n++) begin
        if (phase == 7 && n == 20) idling = 0;
        send_track(rand_track());
      end
      drain();
    end

    $display("Checked %0d tracks (%0d flagged) over %0d register writes,", sb.tracks,
             sb.flagged, cfg_writes);
    $display("with edge-case tracks, random idle gaps, full-rate bursts and full drains.");
    if (sb.errors == 0) $display("PASS track_conversion_tagger");
    else $display("FAIL track_conversion_tagger");
    $finish;
  end

endmodule

[track_conversion_tagger.f]
+incdir+rtl
rtl/tct_pkg.sv
rtl/tct_front.sv
rtl/tct_step.sv
rtl/tct_cut.sv
rtl/track_conversion_tagger.sv
sim/testbench.sv
